// ===== sv/p8c_pkg.sv =====
// ----------------------------------------------------------------------------
// p8c_pkg
// shared types, opcodes, action codes and helpers of the 8-bit pipelined core
// ----------------------------------------------------------------------------
package p8c_pkg;

  localparam int DataW      = 8;
  localparam int RegW       = 4;
  localparam int RegCount   = 16;
  localparam int CntW       = 32;
  localparam int PendW      = 3;
  localparam int InstrDepth = 128;   // one bank of the instruction store
  localparam int DataDepth  = 256;
  localparam int RfPorts    = 4;
  localparam int NumCnt     = 10;

  localparam logic [PendW-1:0] PendMax = 3'd7;

  // action codes
  localparam logic [2:0] ACT_WR_INSTR = 3'd0;
  localparam logic [2:0] ACT_WR_DATA  = 3'd1;
  localparam logic [2:0] ACT_WR_REG   = 3'd2;
  localparam logic [2:0] ACT_TICK     = 3'd3;
  localparam logic [2:0] ACT_RD_DATA  = 3'd4;

  // opcodes
  localparam logic [3:0] OP_ADD  = 4'h0;
  localparam logic [3:0] OP_SUB  = 4'h1;
  localparam logic [3:0] OP_MUL  = 4'h2;
  localparam logic [3:0] OP_INC  = 4'h3;
  localparam logic [3:0] OP_AND  = 4'h4;
  localparam logic [3:0] OP_OR   = 4'h5;
  localparam logic [3:0] OP_XOR  = 4'h6;
  localparam logic [3:0] OP_NOT  = 4'h7;
  localparam logic [3:0] OP_SLL  = 4'h8;
  localparam logic [3:0] OP_SRL  = 4'h9;
  localparam logic [3:0] OP_LI   = 4'hA;
  localparam logic [3:0] OP_LD   = 4'hB;
  localparam logic [3:0] OP_ST   = 4'hC;
  localparam logic [3:0] OP_JMP  = 4'hD;
  localparam logic [3:0] OP_BEQZ = 4'hE;
  localparam logic [3:0] OP_HLT  = 4'hF;

  // counter slots
  localparam int K_INSTR   = 0;
  localparam int K_ARITH   = 1;
  localparam int K_LOGIC   = 2;
  localparam int K_SHIFT   = 3;
  localparam int K_MEMORY  = 4;
  localparam int K_IMM     = 5;
  localparam int K_CONTROL = 6;
  localparam int K_DSTALL  = 7;
  localparam int K_CSTALL  = 8;
  localparam int K_CYCLES  = 9;

  typedef struct packed {
    logic        valid;
    logic [15:0] bits;
  } slot_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             instr;
    logic             arith;
    logic             logic_op;
    logic             shift;
    logic             mem;
    logic             control;
    logic             pc_load;
    logic [DataW-1:0] pc_target;
  } alu_res_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] cnt,
                                              input logic [1:0] inc);
    logic [CntW:0] sum;
    sum = {1'b0, cnt} + (CntW+1)'(inc);
    return sum[CntW] ? {CntW{1'b1}} : sum[CntW-1:0];
  endfunction

endpackage

// ===== sv/p8c_ram.sv =====
// ----------------------------------------------------------------------------
// p8c_ram
// generic single-write, single-read ram with registered, write-first read
// ----------------------------------------------------------------------------
module p8c_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      // same-cycle write wins
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

// ===== sv/p8c_alu.sv =====
// ----------------------------------------------------------------------------
// p8c_alu
// execute stage: result value, branch target and instruction class
// ----------------------------------------------------------------------------
module p8c_alu import p8c_pkg::*; (
  input  logic [15:0]      bits,
  input  logic [DataW-1:0] va,
  input  logic [DataW-1:0] vb,
  input  logic [DataW-1:0] vc,
  input  logic [DataW-1:0] pc,
  output alu_res_t         res
);

  logic [3:0]   op;
  logic [3:0]   fa;
  logic [3:0]   fb;
  logic [3:0]   fc;
  logic [15:0]  prod;

  assign op   = bits[15:12];
  assign fa   = bits[11:8];
  assign fb   = bits[7:4];
  assign fc   = bits[3:0];
  assign prod = 16'(vb) * 16'(vc);

  always_comb begin
    res       = '0;
    res.instr = (op != OP_LI) && (op != OP_HLT);
    case (op)
      OP_ADD:  begin res.value = vb + vc;      res.arith = 1'b1; end
      OP_SUB:  begin res.value = vb - vc;      res.arith = 1'b1; end
      OP_MUL:  begin res.value = prod[7:0];    res.arith = 1'b1; end
      OP_INC:  begin res.value = va + 8'd1;    res.arith = 1'b1; end
      OP_AND:  begin res.value = vb & vc;      res.logic_op = 1'b1; end
      OP_OR:   begin res.value = vb | vc;      res.logic_op = 1'b1; end
      OP_XOR:  begin res.value = vb ^ vc;      res.logic_op = 1'b1; end
      OP_NOT:  begin res.value = ~vb;          res.logic_op = 1'b1; end
      OP_SLL:  begin res.value = vb << fc;     res.shift = 1'b1; end
      OP_SRL:  begin res.value = vb >> fc;     res.shift = 1'b1; end
      OP_LD, OP_ST: begin
        res.value = vb + {{4{fc[3]}}, fc};
        res.mem   = 1'b1;
      end
      OP_JMP: begin
        res.pc_load   = 1'b1;
        res.pc_target = pc + {fa[2:0], fb, 1'b0};
        res.control   = 1'b1;
      end
      OP_BEQZ: begin
        res.pc_load   = (va == '0);
        res.pc_target = pc + {bits[6:0], 1'b0};
        res.control   = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/pipelined_8bit_core.sv =====
// ----------------------------------------------------------------------------
// pipelined_8bit_core
// five-stage 8-bit core driven one word at a time over a valid/stall channel
// ----------------------------------------------------------------------------
// Each input word (store write, register write, clock tick or data read) gives
// one output word with the halt flag, the read byte and the ten saturating
// counters. A new word is taken every cycle unless in_stall is high; its result
// is registered in the execute slot and then in the output registers. The
// instruction store (two 128-byte banks, even and odd bytes), the data store
// and four copies of the register file are synchronous rams with a registered
// read; their read addresses are formed in the accept cycle from the
// next-state values of the word ahead, and the rams return a same-cycle
// write, so back-to-back words see each other's effects.
// A tick runs writeback, memory, execute, decode and fetch together, with
// the writeback value forwarded to the register reads of the same tick.
module pipelined_8bit_core import p8c_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        action,
  input  logic [7:0]        address,
  input  logic [7:0]        write_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              halted,
  output logic [7:0]        read_data,
  output logic [CntW-1:0]   instr_total,
  output logic [CntW-1:0]   arith_total,
  output logic [CntW-1:0]   logic_total,
  output logic [CntW-1:0]   shift_total,
  output logic [CntW-1:0]   memory_total,
  output logic [CntW-1:0]   immediate_total,
  output logic [CntW-1:0]   control_total,
  output logic [CntW-1:0]   data_stalls,
  output logic [CntW-1:0]   control_stalls,
  output logic [CntW-1:0]   cycle_total
);

  localparam int IAddrW = $clog2(InstrDepth);
  localparam int DAddrW = $clog2(DataDepth);

  // pipeline advances unless a finished word is held
  logic advance;

  // word in the execute slot (rams answered)
  logic        b_valid;
  logic [2:0]  b_action;
  logic [7:0]  b_address;
  logic [7:0]  b_wdata;

  // architectural state
  slot_t                f_slot, d_slot, e_slot, m_slot;
  slot_t                f_next, d_next, e_next, m_next;
  logic [DataW-1:0]     val_e, val_m, val_e_next, val_m_next;
  logic [DataW-1:0]     pc, pc_next;
  logic                 branch_wait, branch_wait_next;
  logic                 halt_seen, halt_next;
  logic [PendW-1:0]     pending [RegCount];
  logic [PendW-1:0]     pend_mid [RegCount];
  logic [PendW-1:0]     pending_next [RegCount];
  logic [CntW-1:0]      cnt [NumCnt];
  logic [1:0]           cnt_inc [NumCnt];
  logic [7:0]           read_data_next;

  // ram ports
  logic [DataW-1:0]     ib0_rd, ib1_rd, dm_rd;
  logic [DataW-1:0]     rf_rd [RfPorts];
  logic [RegW-1:0]      rf_raddr [RfPorts];
  logic                 rf_we;
  logic [RegW-1:0]      rf_waddr;
  logic [DataW-1:0]     rf_wdata;
  logic                 dm_we;
  logic [DAddrW-1:0]    dm_waddr, dm_raddr;
  logic [DataW-1:0]     dm_wdata;

  // tick-internal
  logic                 do_tick;
  logic                 wb_we;
  logic [RegW-1:0]      wb_reg;
  logic [DataW-1:0]     wb_val;
  logic [DataW-1:0]     va, vb, vc, st_val;
  alu_res_t             alu;
  logic                 bw;
  logic                 dec_stall;
  logic                 dec_inc;
  logic                 halt_fly;
  logic [DataW-1:0]     pc_tmp;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;
  assign do_tick  = b_valid && (b_action == ACT_TICK) && !halt_seen;

  // ---------------------------------------------------------------- memories
  // even and odd instruction bytes; pc is always even
  p8c_ram #(.Width(DataW), .Depth(InstrDepth)) u_ibank0 (
    .clk   (clk),
    .we    (advance && b_valid && (b_action == ACT_WR_INSTR) && !b_address[0]),
    .waddr (b_address[7:1]),
    .wdata (b_wdata),
    .re    (advance),
    .raddr (pc_next[7:1]),
    .rdata (ib0_rd)
  );

  p8c_ram #(.Width(DataW), .Depth(InstrDepth)) u_ibank1 (
    .clk   (clk),
    .we    (advance && b_valid && (b_action == ACT_WR_INSTR) && b_address[0]),
    .waddr (b_address[7:1]),
    .wdata (b_wdata),
    .re    (advance),
    .raddr (pc_next[7:1]),
    .rdata (ib1_rd)
  );

  // loads read the address in the execute value register; host reads use theirs
  assign dm_raddr = (action == ACT_RD_DATA) ? address : val_e_next;

  p8c_ram #(.Width(DataW), .Depth(DataDepth)) u_dmem (
    .clk   (clk),
    .we    (advance && dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (advance),
    .raddr (dm_raddr),
    .rdata (dm_rd)
  );

  // register file copies: rA, rB, rC of decode, rA of execute (store data)
  assign rf_raddr[0] = d_next.bits[11:8];
  assign rf_raddr[1] = d_next.bits[7:4];
  assign rf_raddr[2] = d_next.bits[3:0];
  assign rf_raddr[3] = e_next.bits[11:8];

  for (genvar g = 0; g < RfPorts; g++) begin : g_rf
    p8c_ram #(.Width(DataW), .Depth(RegCount)) u_rf (
      .clk   (clk),
      .we    (advance && rf_we),
      .waddr (rf_waddr),
      .wdata (rf_wdata),
      .re    (advance),
      .raddr (rf_raddr[g]),
      .rdata (rf_rd[g])
    );
  end

  // writeback value forwarded to reads of the same tick
  assign va     = (wb_we && wb_reg == d_slot.bits[11:8]) ? wb_val : rf_rd[0];
  assign vb     = (wb_we && wb_reg == d_slot.bits[7:4])  ? wb_val : rf_rd[1];
  assign vc     = (wb_we && wb_reg == d_slot.bits[3:0])  ? wb_val : rf_rd[2];
  assign st_val = (wb_we && wb_reg == e_slot.bits[11:8]) ? wb_val : rf_rd[3];

  p8c_alu u_alu (
    .bits (d_slot.bits),
    .va   (va),
    .vb   (vb),
    .vc   (vc),
    .pc   (pc),
    .res  (alu)
  );

  // ------------------------------------------------------------ tick / host
  always_comb begin
    f_next           = f_slot;
    d_next           = d_slot;
    e_next           = e_slot;
    m_next           = m_slot;
    val_e_next       = val_e;
    val_m_next       = val_m;
    pc_tmp           = pc;
    bw               = branch_wait;
    halt_next        = halt_seen;
    wb_we            = 1'b0;
    wb_reg           = m_slot.bits[11:8];
    wb_val           = (m_slot.bits[15:12] == OP_LI) ? m_slot.bits[7:0] : val_m;
    dec_stall        = 1'b0;
    dec_inc          = 1'b0;
    halt_fly         = 1'b0;
    rf_we            = 1'b0;
    rf_waddr         = b_address[3:0];
    rf_wdata         = b_wdata;
    dm_we            = 1'b0;
    dm_waddr         = b_address;
    dm_wdata         = b_wdata;
    for (int k = 0; k < NumCnt; k++) begin
      cnt_inc[k] = 2'd0;
    end
    for (int i = 0; i < RegCount; i++) begin
      pend_mid[i] = pending[i];
    end

    if (b_valid && b_action == ACT_WR_REG) begin
      rf_we = 1'b1;
    end
    if (b_valid && b_action == ACT_WR_DATA) begin
      dm_we = 1'b1;
    end

    if (do_tick) begin
      cnt_inc[K_CYCLES] = 2'd1;
      if (branch_wait) begin
        cnt_inc[K_CSTALL] = 2'd1;
      end
      m_next = '0;
      if (m_slot.valid && m_slot.bits[15:12] == OP_HLT) begin
        // halt retires; nothing else moves
        halt_next        = 1'b1;
        cnt_inc[K_INSTR] = 2'd1;
      end else begin
        // writeback
        if (m_slot.valid && m_slot.bits[15:12] <= OP_LD) begin
          wb_we    = 1'b1;
          rf_we    = 1'b1;
          rf_waddr = wb_reg;
          rf_wdata = wb_val;
          for (int i = 0; i < RegCount; i++) begin
            if (wb_reg == RegW'(i) && pend_mid[i] != '0) begin
              pend_mid[i] = pend_mid[i] - 3'd1;
            end
          end
        end
        // memory
        m_next     = e_slot;
        val_m_next = val_e;
        if (e_slot.valid) begin
          case (e_slot.bits[15:12])
            OP_LD:   val_m_next = dm_rd;
            OP_ST: begin
              dm_we    = 1'b1;
              dm_waddr = val_e;
              dm_wdata = st_val;
            end
            OP_JMP, OP_BEQZ: bw = 1'b0;
            default: ;
          endcase
        end
        // execute
        e_next     = d_slot;
        val_e_next = '0;
        if (d_slot.valid) begin
          val_e_next          = alu.value;
          cnt_inc[K_INSTR]    = {1'b0, alu.instr};
          cnt_inc[K_ARITH]    = {1'b0, alu.arith};
          cnt_inc[K_LOGIC]    = {1'b0, alu.logic_op};
          cnt_inc[K_SHIFT]    = {1'b0, alu.shift};
          cnt_inc[K_MEMORY]   = {1'b0, alu.mem};
          cnt_inc[K_CONTROL]  = {1'b0, alu.control};
          if (alu.pc_load) begin
            pc_tmp = alu.pc_target;
          end
        end
        d_next = '0;
        // decode
        if (!bw) begin
          if (f_slot.valid) begin
            case (f_slot.bits[15:12])
              OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR:
                dec_stall = (pend_mid[f_slot.bits[7:4]] != '0) ||
                            (pend_mid[f_slot.bits[3:0]] != '0);
              OP_INC, OP_BEQZ:
                dec_stall = (pend_mid[f_slot.bits[11:8]] != '0);
              OP_NOT, OP_SLL, OP_SRL, OP_LD:
                dec_stall = (pend_mid[f_slot.bits[7:4]] != '0);
              OP_ST:
                dec_stall = (pend_mid[f_slot.bits[7:4]] != '0) ||
                            (pend_mid[f_slot.bits[11:8]] != '0);
              default: dec_stall = 1'b0;
            endcase
            if (dec_stall) begin
              cnt_inc[K_DSTALL] = 2'd1;
            end else begin
              d_next  = f_slot;
              f_next  = '0;
              dec_inc = (f_slot.bits[15:12] <= OP_LD);
              if (f_slot.bits[15:12] == OP_LI) begin
                cnt_inc[K_INSTR] = cnt_inc[K_INSTR] + 2'd1;
                cnt_inc[K_IMM]   = 2'd1;
              end
              if (f_slot.bits[15:12] == OP_JMP || f_slot.bits[15:12] == OP_BEQZ) begin
                bw = 1'b1;
              end
            end
          end
          // fetch
          if (!dec_stall) begin
            halt_fly = (f_next.valid && f_next.bits[15:12] == OP_HLT) ||
                       (d_next.valid && d_next.bits[15:12] == OP_HLT) ||
                       (e_next.valid && e_next.bits[15:12] == OP_HLT) ||
                       (m_next.valid && m_next.bits[15:12] == OP_HLT);
            if (!bw && !f_next.valid && !halt_fly) begin
              f_next = '{valid: 1'b1, bits: {ib0_rd, ib1_rd}};
              pc_tmp = pc_tmp + 8'd2;
            end
          end
        end
      end
    end

    for (int i = 0; i < RegCount; i++) begin
      pending_next[i] = pend_mid[i];
      if (dec_inc && f_slot.bits[11:8] == RegW'(i) && pend_mid[i] != PendMax) begin
        pending_next[i] = pend_mid[i] + 3'd1;
      end
    end

    branch_wait_next = bw;
    pc_next          = pc_tmp;
    read_data_next   = (b_valid && b_action == ACT_RD_DATA) ? dm_rd : '0;
  end

  // ----------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid     <= 1'b0;
      out_valid   <= 1'b0;
      f_slot      <= '0;
      d_slot      <= '0;
      e_slot      <= '0;
      m_slot      <= '0;
      val_e       <= '0;
      val_m       <= '0;
      pc          <= '0;
      branch_wait <= 1'b0;
      halt_seen   <= 1'b0;
      read_data   <= '0;
      for (int i = 0; i < RegCount; i++) begin
        pending[i] <= '0;
      end
      for (int k = 0; k < NumCnt; k++) begin
        cnt[k] <= '0;
      end
    end else if (advance) begin
      b_valid   <= in_valid;
      out_valid <= b_valid;
      if (b_valid) begin
        f_slot      <= f_next;
        d_slot      <= d_next;
        e_slot      <= e_next;
        m_slot      <= m_next;
        val_e       <= val_e_next;
        val_m       <= val_m_next;
        pc          <= pc_next;
        branch_wait <= branch_wait_next;
        halt_seen   <= halt_next;
        read_data   <= read_data_next;
        for (int i = 0; i < RegCount; i++) begin
          pending[i] <= pending_next[i];
        end
        for (int k = 0; k < NumCnt; k++) begin
          cnt[k] <= sat_inc(cnt[k], cnt_inc[k]);
        end
      end
    end
  end

  // payload of the word in flight
  always_ff @(posedge clk) begin
    if (advance) begin
      b_action  <= action;
      b_address <= address;
      b_wdata   <= write_data;
    end
  end

  assign halted          = halt_seen;
  assign instr_total     = cnt[K_INSTR];
  assign arith_total     = cnt[K_ARITH];
  assign logic_total     = cnt[K_LOGIC];
  assign shift_total     = cnt[K_SHIFT];
  assign memory_total    = cnt[K_MEMORY];
  assign immediate_total = cnt[K_IMM];
  assign control_total   = cnt[K_CONTROL];
  assign data_stalls     = cnt[K_DSTALL];
  assign control_stalls  = cnt[K_CSTALL];
  assign cycle_total     = cnt[K_CYCLES];

endmodule
